// ===== design/path_channel_admission_assert.svh =====
// ----------------------------------------------------------------------------
// path_channel_admission assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PATH_CHANNEL_ADMISSION_ASSERT_SVH
`define PATH_CHANNEL_ADMISSION_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/pca_pkg.sv =====
// ----------------------------------------------------------------------------
// pca_pkg
// Shared widths, codes and beat types of the path channel admission block.
// ----------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

  localparam int LinkW      = 6;
  localparam int HopW       = 4;
  localparam int CapW       = 8;
  localparam int CntW       = 32;
  localparam int LinkFields = 8;
  localparam int IdxW       = 3;

  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_DEPART = 1'b1;

  typedef struct packed {
    logic             func;
    logic [HopW-1:0]  hop_count;
    logic [LinkW-1:0] link_0;
    logic [LinkW-1:0] link_1;
    logic [LinkW-1:0] link_2;
    logic [LinkW-1:0] link_3;
    logic [LinkW-1:0] link_4;
    logic [LinkW-1:0] link_5;
    logic [LinkW-1:0] link_6;
    logic [LinkW-1:0] link_7;
  } req_t;

  typedef struct packed {
    logic            admitted;
    logic [CntW-1:0] accepted_total;
    logic [CntW-1:0] blocked_total;
    logic [CntW-1:0] arrival_total;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/pca_occ_ram.sv =====
// ----------------------------------------------------------------------------
// pca_occ_ram
// Single-port occupancy store, one address per cycle for a read, a write or both, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_occ_ram #(
  parameter int Depth = 64,
  parameter int AddrW = 6,
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/path_channel_admission.sv =====
// ----------------------------------------------------------------------------
// path_channel_admission
// Call admission over per-link channel occupancy held in a single-port RAM.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload        direction
//  --------  ------------------------  -------------  ---------
//  request   start / busy              req_i (req_t)  in
//  result    done_o strobe, one cycle  rsp_o (rsp_t)  out
//  config    cfg_valid_i / cfg_ready_o cfg_data_i     in
//
// One item at a time; busy stays high from acceptance until the result beat.
// An arrival issues one check read per hop on the single RAM port; if it is
// admitted, it then reads and writes back each hop in turn, as a departure
// does. A zero-hop item goes straight to the result beat.
// After reset a clearing pass zeroes every RAM entry with busy high;
// configuration writes are taken throughout. The receiver cannot stall.
`default_nettype none
`include "path_channel_admission_assert.svh"

module path_channel_admission #(
  parameter int NUM_LINKS = 64,
  parameter int MAX_PATH  = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  pca_pkg::req_t             req_i,
  output logic                      done_o,
  output pca_pkg::rsp_t             rsp_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pca_pkg::CapW-1:0]  cfg_data_i
);

  localparam int AW     = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  // compare width: wide enough for both the link id and NUM_LINKS itself
  localparam int CW     = ((AW > pca_pkg::LinkW) ? AW : pca_pkg::LinkW) + 1;
  localparam int HopLim = (MAX_PATH < pca_pkg::LinkFields) ? MAX_PATH
                                                           : pca_pkg::LinkFields;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_UPD_RD = 7'b0001000,
    S_UPD_WR = 7'b0010000,
    S_DONE   = 7'b0100000,
    S_SPARE  = 7'b1000000
  } state_e;

  state_e                       state_q, state_d;
  logic [pca_pkg::HopW-1:0]     idx_q, idx_d;
  logic [pca_pkg::HopW-1:0]     hops_q;
  logic                         func_q;
  logic [pca_pkg::LinkW-1:0]    route_q [pca_pkg::LinkFields];
  logic                         pend_q, pend_d;
  logic                         pend_bad_q, pend_bad_d;
  logic                         full_q, full_d;
  logic                         admitted_q, admitted_d;
  logic [pca_pkg::CntW-1:0]     acc_q, acc_d;
  logic [pca_pkg::CntW-1:0]     blk_q, blk_d;
  logic [AW-1:0]                clr_addr_q, clr_addr_d;
  logic [pca_pkg::CapW-1:0]     cap_q;

  logic                         accept;
  logic [pca_pkg::HopW-1:0]     hops_in;
  logic [pca_pkg::HopW-1:0]     idx_nxt;
  logic [pca_pkg::LinkW-1:0]    cur_id;
  logic [CW-1:0]                cur_ext;
  logic                         cur_ok;
  logic                         eval_full;
  logic [pca_pkg::CapW-1:0]     upd_val;
  logic                         mem_we;
  logic                         mem_re;
  logic [AW-1:0]                mem_addr;
  logic [pca_pkg::CapW-1:0]     mem_wdata;
  logic [pca_pkg::CapW-1:0]     mem_rdata;
  logic [pca_pkg::CntW:0]       total_sum;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Clamp the route length to the supported hop limit.
  assign hops_in = (req_i.hop_count > pca_pkg::HopW'(HopLim)) ? pca_pkg::HopW'(HopLim)
                                                              : req_i.hop_count;

  assign idx_nxt = idx_q + pca_pkg::HopW'(1);

  // Current hop: link ids beyond the table count as having no free channel.
  assign cur_id  = route_q[idx_q[pca_pkg::IdxW-1:0]];
  assign cur_ext = CW'(cur_id);
  assign cur_ok  = (cur_ext < CW'(NUM_LINKS));

  // Evaluate the check read issued in the previous cycle.
  assign eval_full = pend_q && (pend_bad_q || (mem_rdata >= cap_q));

  // Take a channel up to capacity on arrival, give one back down to zero on departure.
  always_comb begin
    if (func_q == pca_pkg::FUNC_ARRIVE) begin
      upd_val = (mem_rdata < cap_q) ? mem_rdata + pca_pkg::CapW'(1) : mem_rdata;
    end else begin
      upd_val = (mem_rdata != '0) ? mem_rdata - pca_pkg::CapW'(1) : mem_rdata;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pend_bad_d = pend_bad_q;
    full_d     = full_q;
    admitted_d = admitted_q;
    acc_d      = acc_q;
    blk_d      = blk_q;
    clr_addr_d = clr_addr_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = cur_ext[AW-1:0];
    mem_wdata  = upd_val;

    case (state_q)
      S_CLEAR: begin
        // Sweep zeroes through the RAM, one entry a cycle.
        mem_we     = 1'b1;
        mem_addr   = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(NUM_LINKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          idx_d  = '0;
          pend_d = 1'b0;
          full_d = 1'b0;
          if (req_i.func == pca_pkg::FUNC_ARRIVE) begin
            if (hops_in == '0) begin
              // Empty route: block straight away.
              admitted_d = 1'b0;
              blk_d      = (blk_q == '1) ? blk_q : blk_q + pca_pkg::CntW'(1);
              state_d    = S_DONE;
            end else begin
              state_d = S_CHECK;
            end
          end else begin
            admitted_d = 1'b1;
            state_d    = (hops_in == '0) ? S_DONE : S_UPD_RD;
          end
        end
      end
      S_CHECK: begin
        // Issue one read per hop while judging the one before.
        pend_d = 1'b0;
        if (eval_full) begin
          full_d = 1'b1;
        end
        if (idx_q != hops_q) begin
          mem_re     = cur_ok;
          pend_d     = 1'b1;
          pend_bad_d = !cur_ok;
          idx_d      = idx_nxt;
        end else if (full_q || eval_full) begin
          admitted_d = 1'b0;
          blk_d      = (blk_q == '1) ? blk_q : blk_q + pca_pkg::CntW'(1);
          state_d    = S_DONE;
        end else begin
          admitted_d = 1'b1;
          acc_d      = (acc_q == '1) ? acc_q : acc_q + pca_pkg::CntW'(1);
          idx_d      = '0;
          state_d    = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        if (cur_ok) begin
          mem_re  = 1'b1;
          state_d = S_UPD_WR;
        end else begin
          // Departure over an unknown link: skip the hop.
          idx_d = idx_nxt;
          if (idx_nxt == hops_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_UPD_WR: begin
        // Write back before the next hop reads, so repeated links see the update.
        mem_we = 1'b1;
        idx_d  = idx_nxt;
        state_d = (idx_nxt == hops_q) ? S_DONE : S_UPD_RD;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      pend_bad_q <= 1'b0;
      full_q     <= 1'b0;
      admitted_q <= 1'b0;
      acc_q      <= '0;
      blk_q      <= '0;
      clr_addr_q <= '0;
      cap_q      <= pca_pkg::CapW'(1);
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      pend_q     <= pend_d;
      pend_bad_q <= pend_bad_d;
      full_q     <= full_d;
      admitted_q <= admitted_d;
      acc_q      <= acc_d;
      blk_q      <= blk_d;
      clr_addr_q <= clr_addr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Hold the accepted beat's payload for the whole item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q     <= req_i.func;
      hops_q     <= hops_in;
      route_q[0] <= req_i.link_0;
      route_q[1] <= req_i.link_1;
      route_q[2] <= req_i.link_2;
      route_q[3] <= req_i.link_3;
      route_q[4] <= req_i.link_4;
      route_q[5] <= req_i.link_5;
      route_q[6] <= req_i.link_6;
      route_q[7] <= req_i.link_7;
    end
  end

  pca_occ_ram #(
    .Depth (NUM_LINKS),
    .AddrW (AW),
    .DataW (pca_pkg::CapW)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Result beat: arrival total saturates at the counter limit.
  assign total_sum = {1'b0, acc_q} + {1'b0, blk_q};

  assign done_o               = (state_q == S_DONE);
  assign rsp_o.admitted       = admitted_q;
  assign rsp_o.accepted_total = acc_q;
  assign rsp_o.blocked_total  = blk_q;
  assign rsp_o.arrival_total  = total_sum[pca_pkg::CntW] ? '1
                                                         : total_sum[pca_pkg::CntW-1:0];

  `PCA_ASSERT_NXT(a_one_result, clk_i, rst_ni, done_o, !done_o && !busy, "result beat repeated")
  `PCA_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, busy, "busy not raised after accept")
  `PCA_ASSERT_IMP(a_blocked_counted, clk_i, rst_ni, done_o && !rsp_o.admitted, rsp_o.blocked_total != '0, "blocked beat with zero count")
  `PCA_ASSERT_IMP(a_write_phase, clk_i, rst_ni, mem_we, (state_q == S_UPD_WR) || (state_q == S_CLEAR), "RAM write outside update")
  `PCA_ASSERT_IMP(a_state_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q), "state not one-hot")

endmodule

`default_nettype wire

// ===== dv/path_channel_admission_test.sv =====
// ----------------------------------------------------------------------------
// path_channel_admission_test
// Drives call arrivals and departures into the admission block, predicts the
// per-link occupancy, admitted flag and counters, and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module path_channel_admission_test;
  import pca_pkg::*;

  localparam int NumLinks   = 64;
  localparam int MaxPath    = 8;
  localparam int Phases     = 10;
  localparam int PhaseCalls = 145;
  // Longest quiet stretch of a correct run: the clearing pass after reset,
  // a sender gap and one full-length admitted arrival. Take it many times.
  localparam int QuietLimit = 1000;

  // Keeps its own copy of the link occupancy and counters, works out the
  // outcome of every accepted call and holds it until the result beat.
  class admission_tracker;
    logic [CapW-1:0] occupancy [NumLinks];
    logic [CapW-1:0] capacity;
    logic [CntW-1:0] accepted;
    logic [CntW-1:0] blocked;
    rsp_t            expected_outcomes [$];
    int unsigned     error_cnt;

    function new();
      foreach (occupancy[i]) occupancy[i] = '0;
      capacity  = 8'd1;
      accepted  = '0;
      blocked   = '0;
      error_cnt = 0;
    endfunction

    function void set_capacity(logic [CapW-1:0] value);
      capacity = value;
    endfunction

    function bit take_call(req_t call);
      logic [LinkW-1:0] route [LinkFields];
      int               hops;
      bit               free_all;
      logic [CntW:0]    sum;
      rsp_t             outcome;
      route[0] = call.link_0;
      route[1] = call.link_1;
      route[2] = call.link_2;
      route[3] = call.link_3;
      route[4] = call.link_4;
      route[5] = call.link_5;
      route[6] = call.link_6;
      route[7] = call.link_7;
      hops = int'(call.hop_count);
      if (hops > MaxPath) hops = MaxPath;
      if (hops > LinkFields) hops = LinkFields;
      outcome = '0;
      outcome.admitted = 1'b1;
      if (call.func == FUNC_ARRIVE) begin
        // check every hop against the occupancy before any update
        free_all = (hops > 0);
        for (int i = 0; i < hops; i++) begin
          if (int'(route[i]) >= NumLinks || occupancy[route[i]] >= capacity) free_all = 1'b0;
        end
        if (free_all) begin
          for (int i = 0; i < hops; i++) begin
            if (occupancy[route[i]] < capacity) occupancy[route[i]] += CapW'(1);
          end
          if (accepted != '1) accepted += CntW'(1);
        end else begin
          outcome.admitted = 1'b0;
          if (blocked != '1) blocked += CntW'(1);
        end
      end else begin
        for (int i = 0; i < hops; i++) begin
          if (int'(route[i]) < NumLinks && occupancy[route[i]] != '0)
            occupancy[route[i]] -= CapW'(1);
        end
      end
      sum = {1'b0, accepted} + {1'b0, blocked};
      outcome.accepted_total = accepted;
      outcome.blocked_total  = blocked;
      outcome.arrival_total  = sum[CntW] ? '1 : sum[CntW-1:0];
      expected_outcomes.push_back(outcome);
      return outcome.admitted;
    endfunction

    function void check_outcome(rsp_t got);
      rsp_t want;
      if (expected_outcomes.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("unexpected result beat: admitted %0d acc %0d blk %0d tot %0d",
                   got.admitted, got.accepted_total, got.blocked_total,
                   got.arrival_total);
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.admitted !== want.admitted || got.accepted_total !== want.accepted_total ||
          got.blocked_total !== want.blocked_total ||
          got.arrival_total !== want.arrival_total) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("result mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   want.admitted, want.accepted_total, want.blocked_total,
                   want.arrival_total, got.admitted, got.accepted_total,
                   got.blocked_total, got.arrival_total);
      end
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  req_t            req_i       = '0;
  logic            done_o;
  rsp_t            rsp_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CapW-1:0] cfg_data_i  = '0;

  admission_tracker tracker = new();
  // admitted arrivals still holding channels, source of well-formed departures
  req_t             live_routes [$];
  int unsigned      quiet_cycles = 0;

  path_channel_admission #(
    .NUM_LINKS (NumLinks),
    .MAX_PATH  (MaxPath)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Check every result beat at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_outcome(rsp_o);
  end

  // Count cycles with no beat on any channel; give up when the run stalls.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Build a route whose link ids step by stride from base, wrapping at 64.
  function automatic req_t route_of(logic func, int hops, int base, int stride);
    req_t             call;
    logic [LinkW-1:0] ids [LinkFields];
    for (int i = 0; i < LinkFields; i++) ids[i] = LinkW'((base + i * stride) % 64);
    call.func      = func;
    call.hop_count = HopW'(hops);
    call.link_0    = ids[0];
    call.link_1    = ids[1];
    call.link_2    = ids[2];
    call.link_3    = ids[3];
    call.link_4    = ids[4];
    call.link_5    = ids[5];
    call.link_6    = ids[6];
    call.link_7    = ids[7];
    return call;
  endfunction

  // Random route. Tame routes draw links mostly from a small pool so that
  // calls contend for the same links; wild ones take any hop count and link.
  function automatic req_t random_route(bit wild);
    req_t        call;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (wild) call.hop_count = HopW'($urandom_range(0, 15));
    else if (r < 4) call.hop_count = '0;
    else if (r < 10) call.hop_count = HopW'($urandom_range(9, 15));
    else call.hop_count = HopW'($urandom_range(1, 8));
    call.func   = FUNC_ARRIVE;
    call.link_0 = (wild || $urandom_range(0, 4) == 0) ? LinkW'($urandom_range(0, 63))
                                                      : LinkW'($urandom_range(0, 11));
    call.link_1 = (wild || $urandom_range(0, 4) == 0) ? LinkW'($urandom_range(0, 63))
                                                      : LinkW'($urandom_range(0, 11));
    call.link_2 = (wild || $urandom_range(0, 4) == 0) ? LinkW'($urandom_range(0, 63))
                                                      : LinkW'($urandom_range(0, 11));
    call.link_3 = (wild || $urandom_range(0, 4) == 0) ? LinkW'($urandom_range(0, 63))
                                                      : LinkW'($urandom_range(0, 11));
    call.link_4 = (wild || $urandom_range(0, 4) == 0) ? LinkW'($urandom_range(0, 63))
                                                      : LinkW'($urandom_range(0, 11));
    call.link_5 = (wild || $urandom_range(0, 4) == 0) ? LinkW'($urandom_range(0, 63))
                                                      : LinkW'($urandom_range(0, 11));
    call.link_6 = (wild || $urandom_range(0, 4) == 0) ? LinkW'($urandom_range(0, 63))
                                                      : LinkW'($urandom_range(0, 11));
    call.link_7 = (wild || $urandom_range(0, 4) == 0) ? LinkW'($urandom_range(0, 63))
                                                      : LinkW'($urandom_range(0, 11));
    return call;
  endfunction

  // Mostly arrivals and the release of calls that were admitted; the rest is
  // noise and departures of calls that never held a channel.
  function automatic req_t next_call();
    req_t        call;
    int unsigned r;
    int unsigned idx;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      call      = random_route(1'b1);
      call.func = logic'($urandom_range(0, 1));
    end else if (r < 56 || live_routes.size() == 0) begin
      call = random_route(1'b0);
    end else if (r < 92) begin
      idx  = $urandom_range(0, live_routes.size() - 1);
      call = live_routes[idx];
      live_routes.delete(idx);
      call.func = FUNC_DEPART;
    end else begin
      call      = random_route(1'b0);
      call.func = FUNC_DEPART;
    end
    return call;
  endfunction

  // Present one call from a falling edge and hold it until the beat is taken.
  task automatic send_call(input req_t call);
    start <= 1'b1;
    req_i <= call;
    do @(posedge clk_i); while (busy);
    if (tracker.take_call(call) && call.func == FUNC_ARRIVE) live_routes.push_back(call);
    @(negedge clk_i);
  endtask

  task automatic idle_for(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Drop start and wait until every outcome has come back.
  task automatic wait_idle();
    start <= 1'b0;
    while (tracker.expected_outcomes.size() != 0 || busy) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_capacity(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CapW-1:0] phase_caps [Phases];
    int unsigned     burst_left;
    bit              steady;
    phase_caps = '{8'd2, 8'd1, 8'd255, 8'd3, 8'd0, 8'd4, 8'd1, 8'd0, 8'd6, 8'd2};
    phase_caps[7] = CapW'($urandom_range(1, 255));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Capacity of one after reset: empty routes, a full link, the floor on
    // departure, a repeated link and a hop count past the route length.
    send_call(route_of(FUNC_ARRIVE, 0, 0, 0));
    send_call(route_of(FUNC_DEPART, 0, 0, 0));
    send_call(route_of(FUNC_ARRIVE, 1, 5, 0));
    send_call(route_of(FUNC_ARRIVE, 1, 5, 0));
    send_call(route_of(FUNC_DEPART, 1, 5, 0));
    send_call(route_of(FUNC_DEPART, 1, 5, 0));
    send_call(route_of(FUNC_ARRIVE, 2, 9, 0));
    send_call(route_of(FUNC_DEPART, 2, 9, 0));
    send_call(route_of(FUNC_ARRIVE, 15, 63, 0));
    send_call(route_of(FUNC_DEPART, 9, 63, 0));

    // Full eight-hop routes at both ends of the link range; one link taken
    // eight times saturates at capacity.
    wait_idle();
    write_capacity(8'd3);
    send_call(route_of(FUNC_ARRIVE, 8, 0, 1));
    send_call(route_of(FUNC_ARRIVE, 8, 56, 1));
    send_call(route_of(FUNC_ARRIVE, 8, 0, 0));
    send_call(route_of(FUNC_ARRIVE, 1, 0, 0));

    // Lower capacity below the occupancy already held.
    wait_idle();
    write_capacity(8'd1);
    send_call(route_of(FUNC_ARRIVE, 1, 3, 0));
    send_call(route_of(FUNC_DEPART, 8, 0, 1));
    send_call(route_of(FUNC_ARRIVE, 1, 3, 0));

    // Capacity of zero leaves every link full.
    wait_idle();
    write_capacity(8'd0);
    send_call(route_of(FUNC_ARRIVE, 1, 20, 0));
    send_call(route_of(FUNC_DEPART, 1, 20, 0));

    wait_idle();
    write_capacity(8'd255);
    send_call(route_of(FUNC_ARRIVE, 8, 0, 0));
    send_call(route_of(FUNC_ARRIVE, 12, 42, 21));
    send_call(route_of(FUNC_DEPART, 15, 0, 0));

    // Random phases, one capacity each; every fourth phase runs without gaps.
    for (int phase = 0; phase < Phases; phase++) begin
      wait_idle();
      write_capacity(phase_caps[phase]);
      steady     = (phase % 4 == 1);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < PhaseCalls; n++) begin
        if (!steady) begin
          if (burst_left == 0) begin
            idle_for($urandom_range(1, 12));
            burst_left = $urandom_range(1, 24);
          end
          burst_left--;
        end
        send_call(next_call());
      end
    end

    wait_idle();
    repeat (32) @(posedge clk_i);
    if (tracker.error_cnt == 0 && tracker.expected_outcomes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/pca_pkg.sv
design/pca_occ_ram.sv
design/path_channel_admission.sv
dv/path_channel_admission_test.sv
